FILE: src/bit_pkg.sv
package bit_pkg;

   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int ROW_AW     = $clog2(MAX_HEIGHT);
   localparam int CNT_W      = ROW_AW + 1;
   localparam int CFG_W      = 7;
   localparam int COL_W      = $clog2(MAX_WIDTH) + 1;

   typedef struct packed {
      logic [MAX_WIDTH-1:0] row_pixels;
      logic                 row_last;
   } req_type;

   typedef struct packed {
      logic [MAX_WIDTH-1:0] out_row_pixels;
      logic                 out_row_last;
   } rsp_type;

   // command from the loader to the thinning engine
   typedef struct packed {
      logic [COL_W-1:0] width;
      logic [CNT_W-1:0] height;
   } job_type;

   // neighbourhood transitions around a ring of eight pixels
   function automatic logic [3:0] crossings(input logic [7:0] s);
      logic [3:0] n;
      n = '0;
      for (int k = 0; k < 8; k++) begin
         if (!s[k] && s[(k + 1) % 8]) begin
            n = n + 4'd1;
         end
      end
      return n;
   endfunction

   // hilditch deletion test for the centre pixel; x[row][col], centre at [2][2]
   function automatic logic pixel_delete(input logic [4:0][4:0] x);
      logic p2, p3, p4, p5, p6, p7, p8, p9;
      logic [3:0] b, a1, a2, a4;
      p2 = x[1][2]; p3 = x[1][3]; p4 = x[2][3]; p5 = x[3][3];
      p6 = x[3][2]; p7 = x[3][1]; p8 = x[2][1]; p9 = x[1][1];
      a1 = crossings({p9, p8, p7, p6, p5, p4, p3, p2});
      a2 = crossings({x[0][1], p9, p8, 1'b1, p4, p3, x[0][3], x[0][2]});
      a4 = crossings({p2, 1'b1, p6, p5, x[3][4], x[2][4], x[1][4], p3});
      b  = 4'(p2) + 4'(p3) + 4'(p4) + 4'(p5) + 4'(p6) + 4'(p7) + 4'(p8) + 4'(p9);
      return x[2][2] && b > 4'd1 && b < 4'd7 && a1 == 4'd1 &&
             (!(p2 && p4 && p8) || a2 != 4'd1) &&
             (!(p2 && p4 && p6) || a4 != 4'd1);
   endfunction

endpackage

FILE: src/binary_image_thinning.sv
// loading: one row per cycle while the engine is not busy; a last row starts
//   thinning, or output if width or height is under 5; each pass copies a
//   snapshot, fills the window, thins each row; passes repeat until nothing
//   clears, time scaling with passes; results wait in the output register
// reset: synchronous active high, clears row count, sequencer and output
//   valid; width register returns to 64, image memories are not cleared
module binary_image_thinning (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  bit_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output bit_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [6:0]       csr_wdata
);
   import bit_pkg::*;

   logic [6:0] width_ff;
   logic       busy, wr_en, job_valid;
   logic [ROW_AW-1:0]    wr_addr;
   logic [MAX_WIDTH-1:0] wr_data;
   job_type    job;

   // width register
   always_ff @(posedge clock) begin
      if (reset) width_ff <= 7'd64;
      else if (csr_we) width_ff <= csr_wdata;
   end

   bit_front u_front (
      .clock, .reset, .req_push, .req_full, .req_data,
      .csr_width(width_ff), .engine_busy(busy),
      .wr_en, .wr_addr, .wr_data, .job_valid, .job
   );

   bit_engine u_engine (
      .clock, .reset, .wr_en, .wr_addr, .wr_data, .job_valid, .job,
      .busy, .rsp_empty, .rsp_pop, .rsp_data
   );
endmodule

FILE: src/bit_front.sv
module bit_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  bit_pkg::req_type  req_data,
   input  logic [6:0]        csr_width,
   input  logic              engine_busy,
   output logic              wr_en,
   output logic [bit_pkg::ROW_AW-1:0]    wr_addr,
   output logic [bit_pkg::MAX_WIDTH-1:0] wr_data,
   output logic              job_valid,
   output bit_pkg::job_type  job
);
   import bit_pkg::*;

   logic [CNT_W-1:0] rows_ff, rows_in;
   logic [COL_W-1:0] w_used;
   logic [MAX_WIDTH-1:0] mask;
   logic acc;

   // saturate width and build column mask
   always_comb begin
      if (csr_width > 7'(MAX_WIDTH)) w_used = COL_W'(MAX_WIDTH);
      else w_used = COL_W'(csr_width);
      for (int k = 0; k < MAX_WIDTH; k++) mask[k] = (k < int'(w_used));
   end

   assign req_full = engine_busy;
   assign acc      = req_push && !engine_busy;
   assign wr_en    = acc && (rows_ff < CNT_W'(MAX_HEIGHT));
   assign wr_addr  = rows_ff[ROW_AW-1:0];
   assign wr_data  = req_data.row_pixels & mask;

   // row counter
   always_comb begin
      rows_in = rows_ff;
      if (acc) begin
         if (req_data.row_last) rows_in = '0;
         else if (wr_en) rows_in = rows_ff + 1'b1;
      end
   end

   assign job_valid  = acc && req_data.row_last;
   assign job.width  = w_used;
   assign job.height = wr_en ? rows_ff + 1'b1 : rows_ff;

   always_ff @(posedge clock) begin
      if (reset) rows_ff <= '0;
      else rows_ff <= rows_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rows_ff <= CNT_W'(MAX_HEIGHT)) else $error("row count overflow");
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      job_valid |=> rows_ff == '0) else $error("count not cleared");
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      engine_busy |-> !wr_en) else $error("write while busy");
endmodule

FILE: src/bit_engine.sv
module bit_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [bit_pkg::ROW_AW-1:0]    wr_addr,
   input  logic [bit_pkg::MAX_WIDTH-1:0] wr_data,
   input  logic              job_valid,
   input  bit_pkg::job_type  job,
   output logic              busy,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output bit_pkg::rsp_type  rsp_data
);
   import bit_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_COPY = 3'd1;
   localparam logic [2:0] ST_FILL = 3'd2;
   localparam logic [2:0] ST_ROW  = 3'd3;
   localparam logic [2:0] ST_NEXT = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [MAX_WIDTH-1:0] img_mem [MAX_HEIGHT];
   logic [MAX_WIDTH-1:0] snap_mem [MAX_HEIGHT];

   logic [2:0]           state_ff, state_in;
   job_type              job_ff, job_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     rd_ff, rd_in;
   logic                 clr_ff, clr_in;
   logic [4:0][MAX_WIDTH-1:0] win_ff, win_in;
   logic [MAX_WIDTH-1:0] img_q, snap_q;
   logic                 q_valid_ff, q_valid_in;
   logic [2:0]           fill_ff, fill_in;
   rsp_type              out_ff, out_in;
   logic                 out_valid_ff, out_valid_in;
   logic [MAX_WIDTH-1:0] new_row;
   logic                 any_clr;
   logic [ROW_AW-1:0]    img_raddr;
   logic [ROW_AW-1:0]    snap_raddr;
   logic                 img_we, snap_we;
   logic [ROW_AW-1:0]    img_waddr, snap_waddr;
   logic [MAX_WIDTH-1:0] img_wdata;
   logic                 take;

   // image memory, one write and one read port
   always_ff @(posedge clock) begin
      if (img_we) img_mem[img_waddr] <= img_wdata;
      img_q <= img_mem[img_raddr];
   end

   // snapshot memory
   always_ff @(posedge clock) begin
      if (snap_we) snap_mem[snap_waddr] <= img_q;
      snap_q <= snap_mem[snap_raddr];
   end

   // thinning of the centre row of the window
   always_comb begin
      logic [4:0][4:0] x;
      new_row = win_ff[2];
      any_clr = 1'b0;
      for (int c = 2; c < MAX_WIDTH - 2; c++) begin
         for (int i = 0; i < 5; i++)
            for (int j = 0; j < 5; j++) x[i][j] = win_ff[i][c - 2 + j];
         if (c < int'(job_ff.width) - 2 && pixel_delete(x)) begin
            new_row[c] = 1'b0;
            any_clr    = 1'b1;
         end
      end
   end

   assign take = rsp_pop && !rsp_empty;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      idx_in       = idx_ff;
      rd_in        = rd_ff;
      clr_in       = clr_ff;
      win_in       = win_ff;
      q_valid_in   = 1'b0;
      fill_in      = fill_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      img_we       = wr_en;
      img_waddr    = wr_addr;
      img_wdata    = wr_data;
      img_raddr    = rd_ff[ROW_AW-1:0];
      snap_we      = 1'b0;
      snap_waddr   = idx_ff[ROW_AW-1:0];
      snap_raddr   = rd_ff[ROW_AW-1:0];
      if (take) out_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_in = job;
               idx_in = '0;
               rd_in  = '0;
               clr_in = 1'b0;
               if (job.width < COL_W'(5) || job.height < CNT_W'(5)) state_in = ST_OUT;
               else state_in = ST_COPY;
            end
         end
         // copy image to snapshot, one row a cycle
         ST_COPY: begin
            if (rd_ff < job_ff.height) rd_in = rd_ff + 1'b1;
            q_valid_in = rd_ff < job_ff.height;
            if (q_valid_ff) begin
               snap_we = 1'b1;
               idx_in  = idx_ff + 1'b1;
               if (idx_ff + 1'b1 == job_ff.height) begin
                  state_in = ST_FILL;
                  idx_in   = '0;
                  rd_in    = '0;
                  fill_in  = '0;
                  clr_in   = 1'b0;
                  win_in   = '0;
               end
            end
         end
         // shift snapshot rows into the five-row window
         ST_FILL: begin
            rd_in      = rd_ff + 1'b1;
            q_valid_in = 1'b1;
            if (q_valid_ff) begin
               win_in  = {snap_q, win_ff[4:1]};
               fill_in = fill_ff + 1'b1;
               if (fill_ff == 3'd4) begin
                  state_in   = ST_ROW;
                  q_valid_in = 1'b0;
                  rd_in      = rd_ff;
                  idx_in     = CNT_W'(2);
               end
            end
         end
         // thin one row and write it back
         ST_ROW: begin
            img_we    = 1'b1;
            img_waddr = idx_ff[ROW_AW-1:0];
            img_wdata = new_row;
            if (any_clr) clr_in = 1'b1;
            if (idx_ff + CNT_W'(3) == job_ff.height) begin
               state_in = clr_in ? ST_COPY : ST_OUT;
               idx_in   = '0;
               rd_in    = '0;
               clr_in   = 1'b0;
               fill_in  = '0;
            end else begin
               state_in = ST_NEXT;
               idx_in   = idx_ff + 1'b1;
            end
         end
         // fetch next snapshot row
         ST_NEXT: begin
            q_valid_in = !q_valid_ff;
            if (!q_valid_ff) rd_in = rd_ff + 1'b1;
            if (q_valid_ff) begin
               win_in   = {(rd_ff - 1'b1 < job_ff.height) ? snap_q : '0, win_ff[4:1]};
               state_in = ST_ROW;
            end
         end
         // emit rows through the output register
         ST_OUT: begin
            // keep re-reading the waiting row while the output is stalled
            if (q_valid_ff) img_raddr = idx_ff[ROW_AW-1:0];
            if (!out_valid_ff || take) begin
               if (!q_valid_ff && rd_ff < job_ff.height) begin
                  rd_in      = rd_ff + 1'b1;
                  q_valid_in = 1'b1;
               end
            end else begin
               q_valid_in = q_valid_ff;
            end
            if (q_valid_ff && (!out_valid_ff || take)) begin
               out_in.out_row_pixels = img_q;
               out_in.out_row_last   = (idx_ff + 1'b1 == job_ff.height);
               out_valid_in          = 1'b1;
               idx_in                = idx_ff + 1'b1;
               q_valid_in            = 1'b0;
               if (idx_ff + 1'b1 == job_ff.height) state_in = ST_IDLE;
            end
            if (job_ff.height == '0) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         q_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         clr_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         q_valid_ff   <= q_valid_in;
         out_valid_ff <= out_valid_in;
         clr_ff       <= clr_in;
      end
      job_ff  <= job_in;
      idx_ff  <= idx_in;
      rd_ff   <= rd_in;
      win_ff  <= win_in;
      fill_ff <= fill_in;
      out_ff  <= out_in;
   end

   assign busy      = (state_ff != ST_IDLE) || out_valid_ff;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   a_no_job_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !job_valid) else $error("job while busy");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !take |=> out_valid_ff) else $error("result lost");
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROW |-> idx_ff + CNT_W'(2) < job_ff.height)
      else $error("row index out of range");
endmodule
